>>> src/led_matrix_clock_frame_scanner_defines.svh
// assertion macros used by the back scanner module (lmcfs_back)
`ifndef LED_MATRIX_CLOCK_FRAME_SCANNER_DEFINES_SVH
`define LED_MATRIX_CLOCK_FRAME_SCANNER_DEFINES_SVH

// condition implies consequence in the same cycle
`define LMCFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the following cycle
`define LMCFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lmcfs_pkg.sv
package lmcfs_pkg;

    localparam int FRAME_COLS  = 48;
    localparam int GROUP_COUNT = 8;
    localparam int GROUP_BYTES = 6;
    localparam int GLYPH_COLS  = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [4:0] HOURS_MAX   = 5'd23;
    localparam logic [5:0] MINUTES_MAX = 6'd59;
    localparam logic [5:0] SECONDS_MAX = 6'd59;

    localparam logic [7:0] BLANK_COL    = 8'hFF;
    localparam logic [7:0] COLON_COL    = 8'hEB;
    localparam logic [7:0] COL_SEL_BASE = 8'h01;

    localparam logic [5:0] COLON_A_COL  = 6'd15;
    localparam logic [5:0] COLON_B_COL  = 6'd32;
    localparam logic [5:0] HOUR_T_COL   = 6'd1;
    localparam logic [5:0] HOUR_U_COL   = 6'd7;
    localparam logic [5:0] MIN_T_COL    = 6'd18;
    localparam logic [5:0] MIN_U_COL    = 6'd24;
    localparam logic [5:0] SEC_T_COL    = 6'd35;
    localparam logic [5:0] SEC_U_COL    = 6'd41;
    localparam logic [5:0] GLYPH_SPAN   = 6'd5;

    localparam logic [2:0] LAST_GROUP = 3'd7;
    localparam logic [2:0] LAST_BYTE  = 3'd5;

    localparam logic [7:0] FONT_ROM [10][GLYPH_COLS] = '{
        '{8'hC1, 8'h80, 8'hAE, 8'hB6, 8'h80, 8'hC1},
        '{8'hFE, 8'hEE, 8'h80, 8'h80, 8'hFE, 8'hFE},
        '{8'hDC, 8'h98, 8'hBA, 8'hB6, 8'h86, 8'hCE},
        '{8'hDD, 8'h9C, 8'hB6, 8'hB6, 8'h80, 8'hC9},
        '{8'hF3, 8'hEB, 8'hDB, 8'h80, 8'h80, 8'hFB},
        '{8'h8D, 8'h8C, 8'hAE, 8'hAE, 8'hA0, 8'hB1},
        '{8'hC1, 8'h80, 8'hB6, 8'hB6, 8'h90, 8'hD9},
        '{8'h9F, 8'h9F, 8'hB8, 8'hA0, 8'h87, 8'h9F},
        '{8'hC9, 8'h80, 8'hB6, 8'hB6, 8'h80, 8'hC9},
        '{8'hCD, 8'h84, 8'hB6, 8'hB6, 8'h80, 8'hC1}
    };

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_in_item;

    typedef struct packed {
        logic [7:0] shift_byte;
        logic [7:0] column_select;
        logic       group_end;
        logic       frame_last;
    } t_out_item;

    // six decimal digits of one sample, hour tens first
    typedef struct packed {
        logic [3:0] hour_t;
        logic [3:0] hour_u;
        logic [3:0] min_t;
        logic [3:0] min_u;
        logic [3:0] sec_t;
        logic [3:0] sec_u;
    } t_digits;

    // handshake bundle between two stages
    typedef struct packed {
        logic   valid;
        t_digits digits;
    } t_digit_xfer;

    // tens of a value below 60
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd50)      t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v, input logic [2:0] t);
        logic [5:0] tenfold;
        logic [5:0] diff;
        tenfold = {t, 3'b000} + {2'b00, t, 1'b0};
        diff    = v - tenfold;
        return diff[3:0];
    endfunction

    function automatic logic [7:0] glyph_byte(input logic [3:0] digit,
                                              input logic [5:0] offset);
        return FONT_ROM[digit][offset[2:0]];
    endfunction

    // frame column contents for a given set of digits
    function automatic logic [7:0] col_byte(input logic [5:0] col, input t_digits d);
        logic [7:0] b;
        case (col) inside
            [HOUR_T_COL : HOUR_T_COL + GLYPH_SPAN]: b = glyph_byte(d.hour_t, col - HOUR_T_COL);
            [HOUR_U_COL : HOUR_U_COL + GLYPH_SPAN]: b = glyph_byte(d.hour_u, col - HOUR_U_COL);
            [MIN_T_COL : MIN_T_COL + GLYPH_SPAN]:   b = glyph_byte(d.min_t, col - MIN_T_COL);
            [MIN_U_COL : MIN_U_COL + GLYPH_SPAN]:   b = glyph_byte(d.min_u, col - MIN_U_COL);
            [SEC_T_COL : SEC_T_COL + GLYPH_SPAN]:   b = glyph_byte(d.sec_t, col - SEC_T_COL);
            [SEC_U_COL : SEC_U_COL + GLYPH_SPAN]:   b = glyph_byte(d.sec_u, col - SEC_U_COL);
            COLON_A_COL, COLON_B_COL:               b = COLON_COL;
            default:                                b = BLANK_COL;
        endcase
        return b;
    endfunction

endpackage

>>> src/led_matrix_clock_frame_scanner.sv
// led matrix clock frame scanner: each transfer on the input carries one time
// sample (hours, minutes, seconds in binary); values above 23/59/59 are
// clamped. the sample is split into six digits, each rendered as a six-column
// glyph from the font rom into a 48-column frame with colon columns 15 and 32
// (0xEB) and blank columns (0xFF). the frame leaves as 48 output transfers,
// one byte per cycle: for column group k = 0..7 the bytes of columns k, k+8,
// .. k+40, the sixth with group_end set and column_select = 1<<k; the 48th
// byte also carries frame_last. the back scanner steps one frame column per
// cycle; a queued sample starts directly after the previous frame with no
// gap. a front register plus a two-entry queue hold pending samples, so the
// input keeps taking samples while a frame scans out until they fill. output
// stalls simply pause the scan
module led_matrix_clock_frame_scanner (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lmcfs_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lmcfs_pkg::t_out_item o_out_data
);
    import lmcfs_pkg::*;

    // front -> queue and queue -> back bundles
    t_digit_xfer front_xfer;
    t_digit_xfer queue_xfer;
    logic        queue_wr_ready;
    logic        back_rd_ready;

    // clamp and digit split, one register stage
    lmcfs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_xfer       (front_xfer),
        .i_xfer_ready (queue_wr_ready)
    );

    // short queue decoupling sample intake from frame scan
    lmcfs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (front_xfer),
        .o_wr_ready (queue_wr_ready),
        .o_rd       (queue_xfer),
        .i_rd_ready (back_rd_ready)
    );

    // frame scanner with registered output
    lmcfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (queue_xfer),
        .o_rd_ready  (back_rd_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> src/lmcfs_front.sv
module lmcfs_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lmcfs_pkg::t_in_item   i_in_data,
    output lmcfs_pkg::t_digit_xfer o_xfer,
    input  logic                  i_xfer_ready
);
    import lmcfs_pkg::*;

    logic       r_valid;
    t_digits    r_digits;
    t_digits    n_digits;
    logic [4:0] hours_c;
    logic [5:0] minutes_c;
    logic [5:0] seconds_c;
    logic [2:0] h_t;
    logic [2:0] m_t;
    logic [2:0] s_t;

    // clamp then split into digits
    always_comb begin
        hours_c   = (i_in_data.hours > HOURS_MAX) ? HOURS_MAX : i_in_data.hours;
        minutes_c = (i_in_data.minutes > MINUTES_MAX) ? MINUTES_MAX : i_in_data.minutes;
        seconds_c = (i_in_data.seconds > SECONDS_MAX) ? SECONDS_MAX : i_in_data.seconds;
        h_t = tens_of({1'b0, hours_c});
        m_t = tens_of(minutes_c);
        s_t = tens_of(seconds_c);
        n_digits.hour_t = {1'b0, h_t};
        n_digits.hour_u = units_of({1'b0, hours_c}, h_t);
        n_digits.min_t  = {1'b0, m_t};
        n_digits.min_u  = units_of(minutes_c, m_t);
        n_digits.sec_t  = {1'b0, s_t};
        n_digits.sec_u  = units_of(seconds_c, s_t);
    end

    assign o_in_ready    = !r_valid || i_xfer_ready;
    assign o_xfer.valid  = r_valid;
    assign o_xfer.digits = r_digits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_digits <= n_digits;
        end
    end

endmodule

>>> src/lmcfs_queue.sv
module lmcfs_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lmcfs_pkg::t_digit_xfer i_wr,
    output logic                   o_wr_ready,
    output lmcfs_pkg::t_digit_xfer o_rd,
    input  logic                   i_rd_ready
);
    import lmcfs_pkg::*;

    t_digits    r_mem [QUEUE_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_wr_ready = (r_count != 2'(QUEUE_DEPTH));
    assign o_rd.valid = (r_count != 2'd0);
    assign o_rd.digits = r_mem[r_rd_ptr];
    assign push = i_wr.valid && o_wr_ready;
    assign pop  = o_rd.valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr.digits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/lmcfs_back.sv
module lmcfs_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lmcfs_pkg::t_digit_xfer i_rd,
    output logic                   o_rd_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output lmcfs_pkg::t_out_item   o_out_data
);
    import lmcfs_pkg::*;
    `include "led_matrix_clock_frame_scanner_defines.svh"

    logic       r_busy;
    logic [2:0] r_k;
    logic [2:0] r_b;
    t_digits    r_digits;
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;
    logic       adv;
    logic       last;
    logic [5:0] col;

    assign adv  = r_busy && (!r_out_valid || i_out_ready);
    assign last = (r_k == LAST_GROUP) && (r_b == LAST_BYTE);
    // column k + 8*b
    assign col  = {r_b, r_k};
    assign o_rd_ready = !r_busy || (adv && last);

    always_comb begin
        n_out.shift_byte    = col_byte(col, r_digits);
        n_out.group_end     = (r_b == LAST_BYTE);
        n_out.column_select = n_out.group_end ? (COL_SEL_BASE << r_k) : 8'h00;
        n_out.frame_last    = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_k         <= 3'd0;
            r_b         <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_rd.valid && o_rd_ready) begin
                r_busy <= 1'b1;
                r_k    <= 3'd0;
                r_b    <= 3'd0;
            end else if (adv) begin
                if (last) begin
                    r_busy <= 1'b0;
                end
                if (r_b == LAST_BYTE) begin
                    r_b <= 3'd0;
                    r_k <= r_k + 3'd1;
                end else begin
                    r_b <= r_b + 3'd1;
                end
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.valid && o_rd_ready) begin
            r_digits <= i_rd.digits;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LMCFS_ASSERT_NOW(a_sel_onehot, i_clk, i_rst_n, r_out_valid, $onehot0(r_out.column_select), "column select not one-hot")
    `LMCFS_ASSERT_NOW(a_sel_on_end, i_clk, i_rst_n, r_out_valid, r_out.group_end == (r_out.column_select != 8'h00), "column select outside group end")
    `LMCFS_ASSERT_NOW(a_last_ends, i_clk, i_rst_n, r_out_valid && r_out.frame_last, r_out.group_end && r_out.column_select[7], "frame end not on last group")
    `LMCFS_ASSERT_NEXT(a_last_out, i_clk, i_rst_n, adv && last, r_out_valid && r_out.frame_last, "frame end byte missing")

endmodule
